@@ rtl/core/rtlpm_pkg.sv @@
package rtlpm_pkg;

  // request op codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_AGE    = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_ROUTE  = 3'd1;
  localparam logic [2:0] ST_BAD_GW    = 3'd2;
  localparam logic [2:0] ST_NO_DEVICE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  // config register indexes
  localparam logic [1:0] CFG_METRIC_INF = 2'd0;
  localparam logic [1:0] CFG_MAX_AGE    = 2'd1;
  localparam logic [1:0] CFG_DEL_DELAY  = 2'd2;

  localparam int unsigned DEVICE_COUNT = 16;
  localparam logic [8:0]  AGE_SAT      = 9'd255;
  localparam logic [5:0]  PREFIX_MAX   = 6'd32;

  typedef struct packed {
    logic       changed;
    logic [8:0] age;
    logic [4:0] metric;
    logic [3:0] dev;
    logic       via;
    logic [5:0] prefix;
  } info_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] gw;
    info_t       info;
  } entry_t;

  typedef enum logic [3:0] {
    U_NOP, U_LOAD, U_SCAN_LOOK, U_SCAN_GW, U_SCAN_POS, U_SCAN_DEL, U_RESTART,
    U_SHIFT, U_PUT, U_REM, U_AGE, U_SORT_K, U_SORT_HOLD, U_SORT_CMP, U_SORT_PUT
  } uop_e;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_GW, S_CHK, S_POS, S_SHIFT, S_PUT, S_DEL, S_REM, S_AGE,
    S_SORT_K, S_SORT_HOLD, S_SORT_CMP, S_SORT_PUT
  } state_e;

  typedef struct packed {
    uop_e       uop;
    logic       res_en;
    logic [2:0] res_status;
    logic       res_hit;
    logic       res_upd;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic done;
    logic have_dev;
    logic full;
    logic shift_done;
    logic precedes;
    logic j_one;
  } stat_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] p);
    logic [31:0] m;
    m = (p == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (PREFIX_MAX - p));
    return m;
  endfunction

  function automatic logic covers(input logic [31:0] dest, input logic [5:0] p,
                                  input logic [31:0] addr);
    return ((addr ^ dest) & prefix_mask(p)) == 32'd0;
  endfunction

  // strict table order: longer prefix, then lower metric, then lower dest
  function automatic logic goes_before(input entry_t a, input entry_t b);
    logic r;
    if (a.info.prefix != b.info.prefix) r = a.info.prefix > b.info.prefix;
    else if (a.info.metric != b.info.metric) r = a.info.metric < b.info.metric;
    else r = a.dest < b.dest;
    return r;
  endfunction

endpackage

@@ rtl/core/rtlpm_ctrl.sv @@
module rtlpm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         op_i,
  input  logic               via_gateway_i,
  input  rtlpm_pkg::stat_t   stat_i,
  output rtlpm_pkg::cmd_t    cmd_o,
  output logic               busy_o
);
  import rtlpm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '{uop: U_NOP, res_en: 1'b0, res_status: ST_OK, res_hit: 1'b0,
                res_upd: 1'b0};
    busy_o  = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.uop = U_LOAD;
          case (op_i)
            OP_LOOKUP: state_d = S_LOOK;
            OP_ADD:    state_d = via_gateway_i ? S_GW : S_CHK;
            OP_DELETE: state_d = S_DEL;
            default:   state_d = S_AGE;
          endcase
        end
      end
      S_LOOK: begin
        cmd_o.uop = U_SCAN_LOOK;
        if (stat_i.hit) begin
          cmd_o.res_en  = 1'b1;
          cmd_o.res_hit = 1'b1;
          state_d = S_IDLE;
        end else if (stat_i.done) begin
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = ST_NO_ROUTE;
          state_d = S_IDLE;
        end
      end
      S_GW: begin
        cmd_o.uop = U_SCAN_GW;
        if (stat_i.hit) state_d = S_CHK;
        else if (stat_i.done) begin
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = ST_BAD_GW;
          state_d = S_IDLE;
        end
      end
      S_CHK: begin
        cmd_o.uop = U_RESTART;
        if (!stat_i.have_dev) begin
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = ST_NO_DEVICE;
          state_d = S_IDLE;
        end else if (stat_i.full) begin
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = ST_FULL;
          state_d = S_IDLE;
        end else state_d = S_POS;
      end
      S_POS: begin
        cmd_o.uop = U_SCAN_POS;
        if (stat_i.hit || stat_i.done) state_d = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.uop = U_SHIFT;
        if (stat_i.shift_done) state_d = S_PUT;
      end
      S_PUT: begin
        cmd_o.uop    = U_PUT;
        cmd_o.res_en = 1'b1;
        state_d = S_IDLE;
      end
      S_DEL: begin
        cmd_o.uop = U_SCAN_DEL;
        if (stat_i.hit) state_d = S_REM;
        else if (stat_i.done) begin
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
          state_d = S_IDLE;
        end
      end
      S_REM: begin
        cmd_o.uop = U_REM;
        if (stat_i.done) begin
          cmd_o.res_en = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_AGE: begin
        cmd_o.uop = U_AGE;
        if (stat_i.done) state_d = S_SORT_K;
      end
      S_SORT_K: begin
        cmd_o.uop = U_SORT_K;
        if (stat_i.done) begin
          cmd_o.res_en  = 1'b1;
          cmd_o.res_upd = 1'b1;
          state_d = S_IDLE;
        end else state_d = S_SORT_HOLD;
      end
      S_SORT_HOLD: begin
        cmd_o.uop = U_SORT_HOLD;
        state_d = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        cmd_o.uop = U_SORT_CMP;
        if (stat_i.precedes && stat_i.j_one) state_d = S_SORT_PUT;
        else if (!stat_i.precedes) state_d = S_SORT_K;
      end
      S_SORT_PUT: begin
        cmd_o.uop = U_SORT_PUT;
        state_d = S_SORT_K;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/rtlpm_dp.sv @@
module rtlpm_dp #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtlpm_pkg::cmd_t    cmd_i,
  output rtlpm_pkg::stat_t   stat_o,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic [31:0]        dest_addr_i,
  input  logic [5:0]         prefix_len_i,
  input  logic               exact_prefix_i,
  input  logic               via_gateway_i,
  input  logic [31:0]        gateway_addr_i,
  input  logic               device_given_i,
  input  logic [3:0]         out_device_i,
  input  logic [4:0]         route_metric_i,
  input  logic signed [8:0]  start_age_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic               hit_via_gateway_o,
  output logic [31:0]        hit_gateway_addr_o,
  output logic [3:0]         hit_device_o,
  output logic [4:0]         hit_metric_o,
  output logic [5:0]         hit_prefix_o,
  output logic               hit_changed_o,
  output logic               update_needed_o
);
  import rtlpm_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] TWO = CW'(2);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q, hold_q, hold_d;

  logic [CW-1:0] cnt_q, cnt_d, ptr_q, ptr_d, wptr_q, wptr_d, pos_q, pos_d;
  logic [CW-1:0] paddr_q, paddr_d;
  logic          pend_q, pend_d, flag_q, flag_d, hdev_q, hdev_d;

  logic [31:0] dest_q, gw_q;
  logic [5:0]  prefix_q;
  logic        exact_q, via_q, dgiven_q;
  logic [3:0]  dev_q, dev_d;
  logic [4:0]  metric_q;
  logic [8:0]  age_q;

  logic [4:0]  inf_q;
  logic [7:0]  maxage_q, delay_q;

  logic          rd_en, wr_en;
  logic [CW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;

  entry_t  new_e, aged_e;
  logic    more, match, hit, done, precedes, poison, drop;
  logic [7:0] a1;
  logic [8:0] thr;

  assign new_e = '{dest: dest_q, gw: gw_q,
                   info: '{changed: 1'b1, age: age_q, metric: metric_q, dev: dev_q,
                           via: via_q, prefix: prefix_q}};

  assign more     = (ptr_q < cnt_q);
  assign precedes = goes_before(hold_q, rdata_q);

  always_comb begin
    case (cmd_i.uop)
      U_SCAN_LOOK: match = covers(rdata_q.dest, rdata_q.info.prefix, dest_q) &&
                           (!exact_q || rdata_q.info.prefix == prefix_q);
      U_SCAN_GW:   match = covers(rdata_q.dest, rdata_q.info.prefix, gw_q);
      U_SCAN_POS:  match = goes_before(new_e, rdata_q);
      U_SCAN_DEL:  match = (rdata_q.dest == dest_q) && (rdata_q.info.prefix == prefix_q);
      default:     match = 1'b0;
    endcase
  end

  assign hit  = pend_q && match;
  assign done = !pend_q && !more;

  // aging of the word under the read pointer
  assign a1     = rdata_q.info.age[7:0] + 8'd1;
  assign thr    = {1'b0, maxage_q} + {1'b0, delay_q};
  assign poison = (a1 == maxage_q);
  assign drop   = !rdata_q.info.age[8] && (rdata_q.info.age != AGE_SAT) && !poison &&
                  ({1'b0, a1} > thr);
  always_comb begin
    aged_e = rdata_q;
    if (!rdata_q.info.age[8] && rdata_q.info.age != AGE_SAT) begin
      aged_e.info.age = {1'b0, a1};
      if (poison) begin
        aged_e.info.metric  = inf_q;
        aged_e.info.changed = 1'b1;
      end
    end
  end

  assign stat_o = '{hit: hit, done: done, have_dev: hdev_q,
                    full: (cnt_q == CW'(TABLE_DEPTH)),
                    shift_done: (ptr_q == pos_q) && !pend_q,
                    precedes: precedes, j_one: (wptr_q == ONE)};

  always_comb begin
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    wptr_d  = wptr_q;
    pos_d   = pos_q;
    paddr_d = paddr_q;
    pend_d  = pend_q;
    flag_d  = flag_q;
    hdev_d  = hdev_q;
    dev_d   = dev_q;
    hold_d  = hold_q;
    rd_en   = 1'b0;
    rd_addr = ptr_q;
    wr_en   = 1'b0;
    wr_addr = paddr_q;
    wr_data = rdata_q;
    case (cmd_i.uop)
      U_LOAD: begin
        ptr_d  = '0;
        wptr_d = '0;
        pend_d = 1'b0;
        flag_d = 1'b0;
        dev_d  = out_device_i;
        hdev_d = device_given_i && ({28'd0, out_device_i} < 32'(DEVICE_COUNT));
      end
      U_SCAN_LOOK, U_SCAN_GW, U_SCAN_POS, U_SCAN_DEL: begin
        if (more && !hit) begin
          rd_en   = 1'b1;
          ptr_d   = ptr_q + ONE;
          pend_d  = 1'b1;
          paddr_d = ptr_q;
        end else pend_d = 1'b0;
        if (cmd_i.uop == U_SCAN_GW && hit && !dgiven_q) begin
          dev_d  = rdata_q.info.dev;
          hdev_d = 1'b1;
        end
        if (cmd_i.uop == U_SCAN_POS && (hit || done)) begin
          pos_d  = hit ? paddr_q : cnt_q;
          ptr_d  = cnt_q;
          pend_d = 1'b0;
        end
        if (cmd_i.uop == U_SCAN_DEL && hit) begin
          ptr_d  = paddr_q + ONE;
          pend_d = 1'b0;
        end
      end
      U_RESTART: begin
        ptr_d  = '0;
        pend_d = 1'b0;
      end
      U_SHIFT: begin
        // open a hole at pos, moving words up by one from the tail
        if (ptr_q > pos_q) begin
          rd_en   = 1'b1;
          rd_addr = ptr_q - ONE;
          paddr_d = ptr_q;
          ptr_d   = ptr_q - ONE;
          pend_d  = 1'b1;
        end else pend_d = 1'b0;
        wr_en = pend_q;
      end
      U_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        wr_data = new_e;
        cnt_d   = cnt_q + ONE;
      end
      U_REM: begin
        if (more) begin
          rd_en   = 1'b1;
          paddr_d = ptr_q - ONE;
          ptr_d   = ptr_q + ONE;
          pend_d  = 1'b1;
        end else pend_d = 1'b0;
        wr_en = pend_q;
        if (done) cnt_d = cnt_q - ONE;
      end
      U_AGE: begin
        if (more) begin
          rd_en  = 1'b1;
          ptr_d  = ptr_q + ONE;
          pend_d = 1'b1;
        end else pend_d = 1'b0;
        if (pend_q) begin
          if (!drop) begin
            wr_en   = 1'b1;
            wr_addr = wptr_q;
            wr_data = aged_e;
            wptr_d  = wptr_q + ONE;
          end
          if (!rdata_q.info.age[8] && rdata_q.info.age != AGE_SAT && poison)
            flag_d = 1'b1;
        end
        if (done) begin
          cnt_d = wptr_q;
          ptr_d = ONE;
        end
      end
      U_SORT_K: begin
        if (more) begin
          rd_en  = 1'b1;
          wptr_d = ptr_q;
        end
      end
      U_SORT_HOLD: begin
        hold_d  = rdata_q;
        rd_en   = 1'b1;
        rd_addr = wptr_q - ONE;
      end
      U_SORT_CMP: begin
        wr_en   = 1'b1;
        wr_addr = wptr_q;
        if (precedes) begin
          wr_data = rdata_q;
          wptr_d  = wptr_q - ONE;
          if (wptr_q >= TWO) begin
            rd_en   = 1'b1;
            rd_addr = wptr_q - TWO;
          end
        end else begin
          wr_data = hold_q;
          ptr_d   = ptr_q + ONE;
        end
      end
      U_SORT_PUT: begin
        wr_en   = 1'b1;
        wr_addr = wptr_q;
        wr_data = hold_q;
        ptr_d   = ptr_q + ONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr[AW-1:0]] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ptr_q    <= '0;
      wptr_q   <= '0;
      pos_q    <= '0;
      paddr_q  <= '0;
      pend_q   <= 1'b0;
      flag_q   <= 1'b0;
      hdev_q   <= 1'b0;
      done_o   <= 1'b0;
      inf_q    <= 5'd16;
      maxage_q <= 8'd6;
      delay_q  <= 8'd4;
    end else begin
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      wptr_q  <= wptr_d;
      pos_q   <= pos_d;
      paddr_q <= paddr_d;
      pend_q  <= pend_d;
      flag_q  <= flag_d;
      hdev_q  <= hdev_d;
      done_o  <= cmd_i.res_en;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_METRIC_INF: inf_q    <= cfg_data_i[4:0];
          CFG_MAX_AGE:    maxage_q <= cfg_data_i;
          CFG_DEL_DELAY:  delay_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    dev_q  <= dev_d;
    if (cmd_i.uop == U_LOAD) begin
      dest_q   <= dest_addr_i;
      gw_q     <= gateway_addr_i;
      prefix_q <= (prefix_len_i > PREFIX_MAX) ? PREFIX_MAX : prefix_len_i;
      exact_q  <= exact_prefix_i;
      via_q    <= via_gateway_i;
      dgiven_q <= device_given_i;
      metric_q <= route_metric_i;
      age_q    <= start_age_i;
    end
    if (cmd_i.res_en) begin
      status_o           <= cmd_i.res_status;
      hit_via_gateway_o  <= cmd_i.res_hit & rdata_q.info.via;
      hit_gateway_addr_o <= cmd_i.res_hit ? rdata_q.gw : 32'd0;
      hit_device_o       <= cmd_i.res_hit ? rdata_q.info.dev : 4'd0;
      hit_metric_o       <= cmd_i.res_hit ? rdata_q.info.metric : 5'd0;
      hit_prefix_o       <= cmd_i.res_hit ? rdata_q.info.prefix : 6'd0;
      hit_changed_o      <= cmd_i.res_hit & rdata_q.info.changed;
      update_needed_o    <= cmd_i.res_upd & flag_q;
    end
  end

endmodule

@@ rtl/core/ipv4_route_table_lpm_core.sv @@
// Channel  | Direction | Handshake                 | Word
// ---------+-----------+---------------------------+-------------------------------
// request  | in        | start_i & !busy_o         | op, addresses, route fields
// result   | out       | done_o, one cycle         | status and matched route
// config   | in        | cfg_valid_i & cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request at a time; busy_o stays high until its result word is issued.
// Lookup scans the table; delete scans, then closes the gap; add scans for the gateway,
// checks device and room, scans for the slot, then shifts and writes; an age tick ages
// and compacts the table, then runs an insertion sort.
// All of it is bound by the single table RAM port pair (one read, one write).
// Reset empties the table at once (route count cleared); config regs take defaults.
// done_o cannot be stalled: the receiver must take the word in that cycle.
module ipv4_route_table_lpm_core #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        op_i,
  input  logic [31:0]       dest_addr_i,
  input  logic [5:0]        prefix_len_i,
  input  logic              exact_prefix_i,
  input  logic              via_gateway_i,
  input  logic [31:0]       gateway_addr_i,
  input  logic              device_given_i,
  input  logic [3:0]        out_device_i,
  input  logic [4:0]        route_metric_i,
  input  logic signed [8:0] start_age_i,
  output logic              done_o,
  output logic [2:0]        status_o,
  output logic              hit_via_gateway_o,
  output logic [31:0]       hit_gateway_addr_o,
  output logic [3:0]        hit_device_o,
  output logic [4:0]        hit_metric_o,
  output logic [5:0]        hit_prefix_o,
  output logic              hit_changed_o,
  output logic              update_needed_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i
);
  import rtlpm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // config writes must only land while idle; the block does not enforce it, they are always taken
  assign cfg_ready_o = 1'b1;

  // sequencer: walks each op through its scan / shift / sort steps
  rtlpm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .op_i          (op_i),
    .via_gateway_i (via_gateway_i),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .busy_o        (busy_o)
  );

  // table RAM, pointers, compare logic and result register
  rtlpm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .dest_addr_i        (dest_addr_i),
    .prefix_len_i       (prefix_len_i),
    .exact_prefix_i     (exact_prefix_i),
    .via_gateway_i      (via_gateway_i),
    .gateway_addr_i     (gateway_addr_i),
    .device_given_i     (device_given_i),
    .out_device_i       (out_device_i),
    .route_metric_i     (route_metric_i),
    .start_age_i        (start_age_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .hit_via_gateway_o  (hit_via_gateway_o),
    .hit_gateway_addr_o (hit_gateway_addr_o),
    .hit_device_o       (hit_device_o),
    .hit_metric_o       (hit_metric_o),
    .hit_prefix_o       (hit_prefix_o),
    .hit_changed_o      (hit_changed_o),
    .update_needed_o    (update_needed_o)
  );

endmodule

@@ bench/tb_ipv4_route_table_lpm_core.sv @@
module tb_ipv4_route_table_lpm_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rtlpm_pkg::*;

  localparam int unsigned DEPTH = 64;
  // cycles without any accepted word before the run is declared hung
  localparam int unsigned HANG_LIMIT = 50000;

  // one request word
  typedef struct {
    logic [1:0]        op;
    logic [31:0]       dest;
    logic [5:0]        prefix;
    logic              exact;
    logic              via;
    logic [31:0]       gw;
    logic              dev_given;
    logic [3:0]        dev;
    logic [4:0]        metric;
    logic signed [8:0] age;
  } req_t;

  // one result word
  typedef struct {
    logic [2:0]  status;
    logic        via;
    logic [31:0] gw;
    logic [3:0]  dev;
    logic [4:0]  metric;
    logic [5:0]  prefix;
    logic        changed;
    logic        upd;
  } res_t;

  // one route as the shadow table holds it
  typedef struct {
    logic [31:0]       dest;
    logic [31:0]       gw;
    logic [5:0]        prefix;
    logic              via;
    logic [3:0]        dev;
    logic [4:0]        metric;
    logic signed [8:0] age;
    logic              changed;
  } route_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [1:0]        op_i = OP_LOOKUP;
  logic [31:0]       dest_addr_i = '0;
  logic [5:0]        prefix_len_i = '0;
  logic              exact_prefix_i = 1'b0;
  logic              via_gateway_i = 1'b0;
  logic [31:0]       gateway_addr_i = '0;
  logic              device_given_i = 1'b0;
  logic [3:0]        out_device_i = '0;
  logic [4:0]        route_metric_i = '0;
  logic signed [8:0] start_age_i = '0;
  logic              done_o;
  logic [2:0]        status_o;
  logic              hit_via_gateway_o;
  logic [31:0]       hit_gateway_addr_o;
  logic [3:0]        hit_device_o;
  logic [4:0]        hit_metric_o;
  logic [5:0]        hit_prefix_o;
  logic              hit_changed_o;
  logic              update_needed_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = CFG_METRIC_INF;
  logic [7:0]        cfg_data_i = '0;

  ipv4_route_table_lpm_core #(.TABLE_DEPTH(DEPTH)) dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow state
  route_t      routes[$];
  res_t        result_q[$];
  logic [4:0]  sh_metric_inf = 5'd16;
  logic [7:0]  sh_max_age = 8'd6;
  logic [7:0]  sh_del_delay = 8'd4;

  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned status_seen[8];
  int unsigned poison_seen = 0;
  bit          no_idle = 1'b0;

  function automatic bit addr_in_prefix(logic [31:0] d, logic [5:0] p, logic [31:0] a);
    if (p == 0) return 1'b1;
    return ((a ^ d) >> (32 - p)) == 0;
  endfunction

  // strict table order: longer prefix, lower metric, lower destination
  function automatic bit route_precedes(route_t a, route_t b);
    if (a.prefix != b.prefix) return a.prefix > b.prefix;
    if (a.metric != b.metric) return a.metric < b.metric;
    return a.dest < b.dest;
  endfunction

  function automatic int first_cover(logic [31:0] a, bit exact, logic [5:0] p);
    foreach (routes[k])
      if (addr_in_prefix(routes[k].dest, routes[k].prefix, a) &&
          (!exact || routes[k].prefix == p))
        return k;
    return -1;
  endfunction

  // applies one request to the shadow table, returns the word it must produce
  function automatic res_t route_table_apply(req_t r);
    res_t   e;
    route_t nr;
    route_t sorted[$];
    logic [5:0] p;
    logic [3:0] dev;
    int k, j, a;
    bit have_dev, flagged;
    e = '{default: '0};
    p = (r.prefix > PREFIX_MAX) ? PREFIX_MAX : r.prefix;
    case (r.op)
      OP_LOOKUP: begin
        k = first_cover(r.dest, r.exact, p);
        if (k < 0) e.status = ST_NO_ROUTE;
        else begin
          e.via = routes[k].via;
          e.gw = routes[k].gw;
          e.dev = routes[k].dev;
          e.metric = routes[k].metric;
          e.prefix = routes[k].prefix;
          e.changed = routes[k].changed;
        end
      end
      OP_ADD: begin
        dev = r.dev;
        have_dev = r.dev_given && (r.dev < DEVICE_COUNT);
        if (r.via) begin
          k = first_cover(r.gw, 1'b0, '0);
          if (k < 0) begin
            e.status = ST_BAD_GW;
            return e;
          end
          if (!r.dev_given) begin
            dev = routes[k].dev;
            have_dev = 1'b1;
          end
        end
        if (!have_dev) e.status = ST_NO_DEVICE;
        else if (routes.size() >= DEPTH) e.status = ST_FULL;
        else begin
          nr = '{dest: r.dest, gw: r.gw, prefix: p, via: r.via, dev: dev,
                 metric: r.metric, age: r.age, changed: 1'b1};
          k = 0;
          while (k < routes.size() && !route_precedes(nr, routes[k])) k++;
          routes.insert(k, nr);
        end
      end
      OP_DELETE: begin
        k = -1;
        foreach (routes[i])
          if (k < 0 && routes[i].dest == r.dest && routes[i].prefix == p) k = i;
        if (k < 0) e.status = ST_NOT_FOUND;
        else routes.delete(k);
      end
      default: begin
        flagged = 1'b0;
        k = 0;
        while (k < routes.size()) begin
          a = int'(routes[k].age);
          if (a < 0 || a >= 255) begin
            k++;
            continue;
          end
          a++;
          if (a == int'(sh_max_age)) begin
            routes[k].metric = sh_metric_inf;
            routes[k].changed = 1'b1;
            routes[k].age = a[8:0];
            flagged = 1'b1;
          end else if (a > int'(sh_max_age) + int'(sh_del_delay)) begin
            routes.delete(k);
            continue;
          end else routes[k].age = a[8:0];
          k++;
        end
        // stable insertion sort
        foreach (routes[i]) begin
          j = sorted.size();
          while (j > 0 && route_precedes(routes[i], sorted[j-1])) j--;
          sorted.insert(j, routes[i]);
        end
        routes = sorted;
        e.upd = flagged;
      end
    endcase
    return e;
  endfunction

  // result checker: done_o cannot be held off, every strobe is a word
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && done_o) begin
      if (result_q.size() == 0) begin
        $error("result word with nothing expected, status %0d", status_o);
        errors++;
      end else begin
        e = result_q.pop_front();
        words_checked++;
        if (status_o != e.status) begin
          $error("status: expected %0d actual %0d", e.status, status_o); errors++;
        end
        if (hit_via_gateway_o != e.via) begin
          $error("hit_via_gateway: expected %0d actual %0d", e.via, hit_via_gateway_o);
          errors++;
        end
        if (hit_gateway_addr_o != e.gw) begin
          $error("hit_gateway_addr: expected %h actual %h", e.gw, hit_gateway_addr_o);
          errors++;
        end
        if (hit_device_o != e.dev) begin
          $error("hit_device: expected %0d actual %0d", e.dev, hit_device_o); errors++;
        end
        if (hit_metric_o != e.metric) begin
          $error("hit_metric: expected %0d actual %0d", e.metric, hit_metric_o); errors++;
        end
        if (hit_prefix_o != e.prefix) begin
          $error("hit_prefix: expected %0d actual %0d", e.prefix, hit_prefix_o); errors++;
        end
        if (hit_changed_o != e.changed) begin
          $error("hit_changed: expected %0d actual %0d", e.changed, hit_changed_o);
          errors++;
        end
        if (update_needed_o != e.upd) begin
          $error("update_needed: expected %0d actual %0d", e.upd, update_needed_o);
          errors++;
        end
      end
    end
  end

  // hang detector: any accepted word on any channel resets the count
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_t blank_req(logic [1:0] op);
    req_t r;
    r = '{default: '0};
    r.op = op;
    return r;
  endfunction

  // sends one request word; called right after a rising edge
  task automatic send_req(input req_t r);
    int gap;
    res_t e;
    start_i <= 1'b1;
    op_i <= r.op;
    dest_addr_i <= r.dest;
    prefix_len_i <= r.prefix;
    exact_prefix_i <= r.exact;
    via_gateway_i <= r.via;
    gateway_addr_i <= r.gw;
    device_given_i <= r.dev_given;
    out_device_i <= r.dev;
    route_metric_i <= r.metric;
    start_age_i <= r.age;
    do @(posedge clk_i); while (busy_o);
    e = route_table_apply(r);
    result_q.push_back(e);
    words_sent++;
    status_seen[e.status]++;
    if (e.upd) poison_seen++;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // lowers start and waits until every expected word has come
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (result_q.size() != 0 || busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_METRIC_INF: sh_metric_inf = val[4:0];
      CFG_MAX_AGE:    sh_max_age = val;
      default:        sh_del_delay = val;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [4:0] inf, input logic [7:0] mx,
                            input logic [7:0] dl);
    drain();
    cfg_write(CFG_METRIC_INF, {3'b0, inf});
    cfg_write(CFG_MAX_AGE, mx);
    cfg_write(CFG_DEL_DELAY, dl);
  endtask

  task automatic put_route(input logic [31:0] d, input logic [5:0] p, input bit via,
                           input logic [31:0] g, input bit dg, input logic [3:0] dev,
                           input logic [4:0] m, input logic signed [8:0] age);
    req_t r;
    r = blank_req(OP_ADD);
    r.dest = d; r.prefix = p; r.via = via; r.gw = g;
    r.dev_given = dg; r.dev = dev; r.metric = m; r.age = age;
    send_req(r);
  endtask

  task automatic lookup(input logic [31:0] a, input bit ex, input logic [5:0] p);
    req_t r;
    r = blank_req(OP_LOOKUP);
    r.dest = a; r.exact = ex; r.prefix = p;
    send_req(r);
  endtask

  task automatic del_route(input logic [31:0] d, input logic [5:0] p);
    req_t r;
    r = blank_req(OP_DELETE);
    r.dest = d; r.prefix = p;
    send_req(r);
  endtask

  // lookups, adds, gateway and device rules, deletes, prefix saturation
  task automatic test_basic_ops();
    lookup(32'hC0A8_0101, 1'b0, 6'd0);                         // empty table miss
    put_route(32'h0A00_0000, 6'd8, 1'b0, '0, 1'b0, 4'd0, 5'd1, -9'sd1); // no device
    put_route(32'h0A00_0000, 6'd8, 1'b1, 32'h0102_0304, 1'b1, 4'd2, 5'd1, -9'sd1);
    put_route(32'hC0A8_0000, 6'd16, 1'b0, 32'hFFFF_FFFF, 1'b1, 4'd15, 5'd31, -9'sd256);
    put_route(32'h0A00_0000, 6'd8, 1'b1, 32'hC0A8_0101, 1'b0, 4'd0, 5'd0, -9'sd1);
    put_route(32'hFFFF_FFFF, 6'd63, 1'b0, '0, 1'b1, 4'd3, 5'd2, -9'sd1); // /63 -> /32
    put_route(32'h0000_0000, 6'd0, 1'b0, '0, 1'b1, 4'd1, 5'd0, -9'sd1);  // default
    lookup(32'h0A01_0203, 1'b0, 6'd0);
    lookup(32'hFFFF_FFFF, 1'b0, 6'd0);
    lookup(32'hFFFF_FFFF, 1'b1, 6'd40);
    lookup(32'hC0A8_7777, 1'b1, 6'd8);
    lookup(32'h8000_0000, 1'b0, 6'd0);
    del_route(32'hC0A8_0000, 6'd24);                           // not found
    del_route(32'hFFFF_FFFF, 6'd33);
    lookup(32'hFFFF_FFFF, 1'b0, 6'd0);
  endtask

  // poisoning, removal, manual routes, start past max, saturated age
  task automatic test_aging();
    req_t t;
    t = blank_req(OP_AGE);
    put_route(32'h1100_0000, 6'd8, 1'b0, '0, 1'b1, 4'd4, 5'd3, 9'sd5);
    put_route(32'h2200_0000, 6'd8, 1'b0, '0, 1'b1, 4'd5, 5'd3, 9'sd8);
    put_route(32'h3300_0000, 6'd8, 1'b0, '0, 1'b1, 4'd6, 5'd3, 9'sd255);
    put_route(32'h4400_0000, 6'd8, 1'b0, '0, 1'b1, 4'd7, 5'd3, 9'sd250);
    send_req(t);
    lookup(32'h1100_0001, 1'b0, 6'd0);
    lookup(32'h2200_0001, 1'b0, 6'd0);
    repeat (3) send_req(t);
    lookup(32'h3300_0001, 1'b1, 6'd8);
    lookup(32'h1100_0001, 1'b1, 6'd8);
  endtask

  // fill to capacity, overflow, then empty again
  task automatic test_table_full();
    logic [31:0] d;
    int n;
    drain();
    n = 0;
    while (routes.size() < DEPTH && n < 200) begin
      d = $urandom();
      put_route(d, 6'($urandom_range(0, 32)), 1'b0, $urandom(), 1'b1,
                4'($urandom()), 5'($urandom()), -9'sd1);
      n++;
    end
    put_route(32'h5555_5555, 6'd32, 1'b0, '0, 1'b1, 4'd9, 5'd9, -9'sd1);
    lookup(32'h5555_5555, 1'b0, 6'd0);
    lookup($urandom(), 1'b0, 6'd0);
    drain();
    while (routes.size() > 0) del_route(routes[0].dest, routes[0].prefix);
  endtask

  // one well-formed request with random content, or noise
  task automatic random_item();
    req_t r;
    int sel, k;
    logic [31:0] base[8] = '{32'h0A00_0000, 32'hC0A8_0000, 32'hAC10_0000, 32'h0000_0000,
                             32'hFFFF_FF00, 32'h7F00_0000, 32'h8000_0000, 32'hE000_0000};
    sel = $urandom_range(0, 99);
    r = blank_req(OP_LOOKUP);
    if (sel < 8) begin
      // noise: every field at random
      r.op = 2'($urandom()); r.dest = $urandom(); r.prefix = 6'($urandom());
      r.exact = 1'($urandom()); r.via = 1'($urandom()); r.gw = $urandom();
      r.dev_given = 1'($urandom()); r.dev = 4'($urandom());
      r.metric = 5'($urandom()); r.age = 9'($urandom());
    end else if (sel < 45) begin
      r.op = OP_LOOKUP;
      if (routes.size() > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, routes.size() - 1);
        r.dest = routes[k].dest ^ ($urandom() >> (routes[k].prefix == 0 ? 0 :
                                                   routes[k].prefix));
        r.prefix = routes[k].prefix;
      end else begin
        r.dest = base[$urandom_range(0, 7)] | ($urandom() & 32'h00FF_FFFF);
        r.prefix = 6'($urandom_range(0, 63));
      end
      r.exact = ($urandom_range(0, 3) == 0);
    end else if (sel < 75) begin
      r.op = OP_ADD;
      r.dest = base[$urandom_range(0, 7)] | ($urandom() & 32'h00FF_FFFF);
      case ($urandom_range(0, 5))
        0: r.prefix = 6'd0;
        1: r.prefix = 6'd32;
        2: r.prefix = 6'($urandom_range(33, 63));
        default: r.prefix = 6'($urandom_range(1, 31));
      endcase
      r.via = ($urandom_range(0, 2) == 0);
      if (r.via && routes.size() > 0 && $urandom_range(0, 3) != 0)
        r.gw = routes[$urandom_range(0, routes.size() - 1)].dest;
      else r.gw = $urandom();
      r.dev_given = ($urandom_range(0, 6) != 0);
      r.dev = 4'($urandom());
      r.metric = 5'($urandom());
      case ($urandom_range(0, 5))
        0: r.age = -9'sd1;
        1: r.age = 9'($urandom()) | 9'h100;
        2: r.age = 9'($urandom_range(0, 255));
        default: r.age = 9'($urandom_range(0, 12));
      endcase
    end else if (sel < 88) begin
      r.op = OP_DELETE;
      if (routes.size() > 0 && $urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, routes.size() - 1);
        r.dest = routes[k].dest;
        r.prefix = (routes[k].prefix == 6'd32 && $urandom_range(0, 1)) ?
                   6'($urandom_range(32, 63)) : routes[k].prefix;
      end else begin
        r.dest = $urandom();
        r.prefix = 6'($urandom());
      end
    end else begin
      r.op = OP_AGE;
    end
    send_req(r);
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(5'd16, 8'd6, 8'd4);
        1: set_config(5'd1, 8'd1, 8'd1);
        2: set_config(5'd31, 8'd255, 8'd255);
        3: set_config(5'd31, 8'd3, 8'd255);
        4: set_config(5'd8, 8'd255, 8'd1);
        default: set_config(5'($urandom_range(1, 31)), 8'($urandom_range(1, 255)),
                            8'($urandom_range(1, 255)));
      endcase
      for (int i = 0; i < 160; i++) begin
        no_idle = (i >= 60 && i < 90);       // a burst with no gaps
        random_item();
        if (i == 120) drain();              // pause until nothing is outstanding
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_aging();
    test_table_full();
    test_random_traffic();
    drain();
    repeat (50) @(posedge clk_i);
    $display("sent %0d request words, checked %0d result words, %0d age ticks poisoned",
             words_sent, words_checked, poison_seen);
    $display("status mix ok/miss/gw/dev/full/notfound: %0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (errors == 0 && result_q.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
